### design/ntc_thermistor_beta_temperature_core_defines.svh
// ----------------------------------------------------------------------------
// NTC Beta temperature core: assertion macros
// Shared concurrent assertion shorthands for the NTC temperature core.
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_BETA_TEMPERATURE_CORE_DEFINES_SVH
`define NTC_THERMISTOR_BETA_TEMPERATURE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define NTCB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// An implication checked in the same cycle.
`define NTCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/ntcb_pkg.sv
// ----------------------------------------------------------------------------
// NTC Beta temperature package
// Constants and register indexes shared by the NTC temperature core.
// ----------------------------------------------------------------------------
package ntcb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SUPPLY  = 3'd0;
  localparam logic [2:0] REG_SERIES  = 3'd1;
  localparam logic [2:0] REG_NOMINAL = 3'd2;
  localparam logic [2:0] REG_BETA    = 3'd3;
  localparam logic [2:0] REG_T0      = 3'd4;

  // Register reset values.
  localparam logic [12:0]        SUPPLY_RST  = 13'd3300;
  localparam logic [19:0]        SERIES_RST  = 20'd10000;
  localparam logic [19:0]        NOMINAL_RST = 20'd10000;
  localparam logic [13:0]        BETA_RST    = 14'd3950;
  localparam logic signed [14:0] T0_RST      = 15'sd2500;

  // Arithmetic constants.
  localparam logic [11:0]        RAW_SPAN_MV    = 12'd3300;
  localparam logic [16:0]        KELVIN_OFFSET  = 17'd27315;
  localparam logic [29:0]        LN2_Q30        = 30'd744261118;
  localparam logic [36:0]        SCALE_Q30      = 37'd100 << 30;
  localparam int                 LOG_FRAC_BITS  = 24;
  localparam logic signed [17:0] TEMP_MAX       = 18'sd99999;
  localparam logic signed [17:0] TEMP_MIN       = -18'sd99900;

endpackage

### design/ntcb_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a side payload carried along.
// The numerator must be below the divisor shifted left by the quotient width.
// ----------------------------------------------------------------------------
module ntcb_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  localparam int CW = (NW > DW) ? NW : DW;

  logic          v_s   [QW+1];
  logic [NW-1:0] rem_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [PW-1:0] pay_s [QW+1];

  // Stage zero is the input itself.
  assign v_s[0]   = valid_i;
  assign rem_s[0] = num_i;
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;
  assign pay_s[0] = pay_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;

    logic [CW-1:0] hi;
    logic [CW-1:0] dx;
    logic          take;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    // Trial subtraction of the divisor at this bit weight.
    always_comb begin
      hi    = CW'(rem_s[k] >> Bit);
      dx    = CW'(den_s[k]);
      take  = (hi >= dx);
      rem_d = take ? (rem_s[k] - (NW'(den_s[k]) << Bit)) : rem_s[k];
      quo_d = quo_s[k];
      quo_d[Bit] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1] <= rem_d;
        den_s[k+1] <= den_s[k];
        quo_s[k+1] <= quo_d;
        pay_s[k+1] <= pay_s[k];
      end
    end
  end

  assign valid_o = v_s[QW];
  assign quo_o   = quo_s[QW];
  assign pay_o   = pay_s[QW];

endmodule

### design/ntcb_log2.sv
// ----------------------------------------------------------------------------
// Pipelined base-two logarithm
// Normalises a Q16.16 ratio and extracts the fraction by repeated squaring,
// one squaring per register stage. The result is signed Q5.24.
// ----------------------------------------------------------------------------
module ntcb_log2
  import ntcb_pkg::*;
#(
  parameter int PW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         x_i,
  input  logic [PW-1:0]       pay_i,
  output logic                valid_o,
  output logic signed [28:0]  log2_o,
  output logic [PW-1:0]       pay_o
);

  localparam int FW = LOG_FRAC_BITS;

  // Leading one search, registered.
  logic [4:0]    top_d;
  logic [4:0]    top_q;
  logic [31:0]   x_q;
  logic          va_q;
  logic [PW-1:0] pa_q;

  always_comb begin
    top_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) begin
        top_d = 5'(i);
      end
    end
  end

  // Normalised mantissa in Q1.30 and exponent relative to Q16.16.
  logic [30:0]   man_d;
  logic [4:0]    shamt;

  always_comb begin
    shamt = 5'd30 - top_q;
    if (top_q == 5'd31) begin
      man_d = x_q[31:1];
    end else begin
      man_d = 31'(x_q << shamt);
    end
  end

  logic          v_s   [FW+1];
  logic [30:0]   man_s [FW+1];
  logic [FW-1:0] frac_s[FW+1];
  logic [4:0]    exp_s [FW+1];
  logic [PW-1:0] pay_s [FW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      va_q   <= valid_i;
      v_s[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q     <= top_d;
      x_q       <= x_i;
      pa_q      <= pay_i;
      man_s[0]  <= man_d;
      frac_s[0] <= '0;
      // Exponent minus sixteen, as a five-bit two's complement value.
      exp_s[0]  <= {~top_q[4], top_q[3:0]};
      pay_s[0]  <= pa_q;
    end
  end

  for (genvar k = 0; k < FW; k++) begin : g_square
    logic [61:0] sq;
    logic [31:0] sq_hi;
    logic [30:0] man_d2;
    logic        bit_d;

    // Square the mantissa; an overflow past two yields a fraction bit of one.
    always_comb begin
      sq     = 62'(man_s[k]) * 62'(man_s[k]);
      sq_hi  = sq[61:30];
      bit_d  = sq_hi[31];
      man_d2 = bit_d ? sq_hi[31:1] : sq_hi[30:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        man_s[k+1]  <= man_d2;
        frac_s[k+1] <= {frac_s[k][FW-2:0], bit_d};
        exp_s[k+1]  <= exp_s[k];
        pay_s[k+1]  <= pay_s[k];
      end
    end
  end

  assign valid_o = v_s[FW];
  assign log2_o  = $signed({exp_s[FW], frac_s[FW]});
  assign pay_o   = pay_s[FW];

endmodule

### design/ntc_thermistor_beta_temperature_core.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature core (Beta equation)
// Converts a divider voltage sample into a temperature in 0.01 degC.
// ----------------------------------------------------------------------------
// The core accepts one sample every clock cycle while the output is not
// stalled, and returns one result per sample, in order. The pipeline includes
// the bit-per-stage dividers for the resistance ratio, the division by Beta and
// the final reciprocal, and the 24 squaring stages of the logarithm. The whole
// pipeline holds while a finished result is stalled at the output. A raw ADC
// code is scaled to millivolts, the thermistor resistance ratio is formed
// against the series and nominal resistors, and the Beta equation gives the
// temperature. Voltages of zero, or at or above the supply, report a read
// error with -99900. Other results saturate to -99900..99999. Configuration
// writes must be made while no sample is in flight.
module ntc_thermistor_beta_temperature_core
  import ntcb_pkg::*;
#(
  parameter int ADC_FULL_SCALE_CODE = 4095
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [12:0]        sample_value_i,
  input  logic               is_millivolts_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] temp_centi_c_o,
  output logic               read_error_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i
);

`include "ntc_thermistor_beta_temperature_core_defines.svh"

  // Configuration registers.
  logic [12:0]        vcc_q;
  logic [19:0]        rs_q;
  logic [19:0]        r0_q;
  logic [13:0]        beta_q;
  logic signed [14:0] t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcc_q  <= SUPPLY_RST;
      rs_q   <= SERIES_RST;
      r0_q   <= NOMINAL_RST;
      beta_q <= BETA_RST;
      t0_q   <= T0_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SUPPLY:  vcc_q  <= cfg_wdata_i[12:0];
        REG_SERIES:  rs_q   <= cfg_wdata_i;
        REG_NOMINAL: r0_q   <= cfg_wdata_i;
        REG_BETA:    beta_q <= cfg_wdata_i[13:0];
        REG_T0:      t0_q   <= $signed(cfg_wdata_i[14:0]);
        default: ;
      endcase
    end
  end

  // A zero nominal resistor or Beta behaves as one.
  logic [19:0] r0_eff;
  logic [13:0] beta_eff;
  logic [16:0] t0_kelvin;

  assign r0_eff    = (r0_q == '0) ? 20'd1 : r0_q;
  assign beta_eff  = (beta_q == '0) ? 14'd1 : beta_q;
  assign t0_kelvin = {{2{t0_q[14]}}, t0_q} + KELVIN_OFFSET;

  // The pipeline advances unless a result waits at a stalled output.
  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Input stage: raw code times the ADC span.
  logic        v1_q;
  logic [24:0] prod1_q;
  logic [12:0] smp1_q;
  logic        mv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod1_q <= 25'(sample_value_i) * 25'(RAW_SPAN_MV);
      smp1_q  <= sample_value_i;
      mv1_q   <= is_millivolts_i;
    end
  end

  // Scale to millivolts by the ADC full-scale code. The division is a multiply
  // by the rounded-up reciprocal; with this shift the floor is exact for every
  // 25-bit product.
  localparam int          MV_SH  = 25 + $clog2(ADC_FULL_SCALE_CODE);
  localparam logic [25:0] MV_MUL =
    26'(((64'd1 << MV_SH) + 64'(ADC_FULL_SCALE_CODE) - 64'd1) / 64'(ADC_FULL_SCALE_CODE));

  logic        vd_valid_q;
  logic [50:0] mvp_q;
  logic [13:0] vd_pay_q;
  logic [24:0] vd_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_valid_q <= 1'b0;
    end else if (en) begin
      vd_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mvp_q    <= 51'(prod1_q) * 51'(MV_MUL);
      vd_pay_q <= {mv1_q, smp1_q};
    end
  end

  assign vd_quo = 25'(mvp_q >> MV_SH);

  // Range check against the supply, and the voltage across the thermistor.
  logic [24:0] v_full;
  logic        err2_d;
  logic        v2_q;
  logic        err2_q;
  logic [12:0] volt2_q;
  logic [12:0] diff2_q;

  assign v_full = vd_pay_q[13] ? 25'(vd_pay_q[12:0]) : vd_quo;
  assign err2_d = (v_full == '0) || (v_full >= 25'(vcc_q));

  // Numerator and denominator products of the resistance ratio.
  logic        v3_q;
  logic        err3_q;
  logic [32:0] nump3_q;
  logic [32:0] denp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v2_q <= vd_valid_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err2_q  <= err2_d;
      volt2_q <= v_full[12:0];
      diff2_q <= vcc_q - v_full[12:0];
      err3_q  <= err2_q;
      nump3_q <= 33'(rs_q) * 33'(diff2_q);
      denp3_q <= 33'(volt2_q) * 33'(r0_eff);
    end
  end

  // A ratio of 2^32 or more saturates; its division is then skipped.
  logic        ratio_sat;
  logic [48:0] rnum;

  assign ratio_sat = (33'(nump3_q[32:16]) >= denp3_q);
  assign rnum      = (err3_q || ratio_sat) ? '0 : {nump3_q, 16'h0000};

  logic        rd_valid;
  logic [31:0] rd_quo;
  logic [1:0]  rd_pay;

  ntcb_div #(
    .NW (49),
    .DW (33),
    .QW (32),
    .PW (2)
  ) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (rnum),
    .den_i   (denp3_q),
    .pay_i   ({err3_q, ratio_sat}),
    .valid_o (rd_valid),
    .quo_o   (rd_quo),
    .pay_o   (rd_pay)
  );

  // Clamp the ratio to 1..2^32-1 in Q16.16.
  logic [31:0] ratio;

  always_comb begin
    if (rd_pay[0]) begin
      ratio = '1;
    end else if (rd_quo == '0) begin
      ratio = 32'd1;
    end else begin
      ratio = rd_quo;
    end
  end

  logic               lg_valid;
  logic signed [28:0] lg_val;
  logic               lg_err;

  ntcb_log2 #(
    .PW (1)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rd_valid),
    .x_i     (ratio),
    .pay_i   (rd_pay[1]),
    .valid_o (lg_valid),
    .log2_o  (lg_val),
    .pay_o   (lg_err)
  );

  // Magnitude of log2, then the natural log in Q.30 by a multiply with ln 2.
  logic        v6_q;
  logic        err6_q;
  logic        neg6_q;
  logic [28:0] mag6_q;
  logic        v7_q;
  logic        err7_q;
  logic        neg7_q;
  logic [33:0] ln7_q;
  logic [58:0] ln_prod;

  assign ln_prod = 59'(mag6_q) * 59'(LN2_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v6_q <= lg_valid;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err6_q <= lg_err;
      neg6_q <= lg_val[28];
      mag6_q <= lg_val[28] ? 29'(-lg_val) : 29'(lg_val);
      err7_q <= err6_q;
      neg7_q <= neg6_q;
      ln7_q  <= ln_prod[57:24];
    end
  end

  // ln / Beta and 1 / T0 run side by side with equal latency.
  logic        bd_valid;
  logic [33:0] bd_quo;
  logic        bd_neg;
  logic        td_valid;
  logic [33:0] td_quo;
  logic        td_err;

  ntcb_div #(
    .NW (34),
    .DW (14),
    .QW (34),
    .PW (1)
  ) u_div_beta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (ln7_q),
    .den_i   (beta_eff),
    .pay_i   (neg7_q),
    .valid_o (bd_valid),
    .quo_o   (bd_quo),
    .pay_o   (bd_neg)
  );

  ntcb_div #(
    .NW (37),
    .DW (16),
    .QW (34),
    .PW (1)
  ) u_div_t0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (SCALE_Q30),
    .den_i   (t0_kelvin[15:0]),
    .pay_i   (err7_q),
    .valid_o (td_valid),
    .quo_o   (td_quo),
    .pay_o   (td_err)
  );

  // Sum of the two reciprocal terms, signed Q.30.
  logic signed [35:0] lnb_s;
  logic signed [35:0] s_d;
  logic               v8_q;
  logic               err8_q;
  logic signed [35:0] s8_q;

  assign lnb_s = $signed({2'b00, bd_quo});
  assign s_d   = (bd_neg ? -lnb_s : lnb_s) + $signed({2'b00, td_quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= bd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err8_q <= td_err;
      s8_q   <= s_d;
    end
  end

  // Final reciprocal with rounding: (scale + s/2) / s.
  logic        s_pos;
  logic [37:0] fnum;
  logic [34:0] fden;

  assign s_pos = !s8_q[35] && (s8_q != '0);
  assign fnum  = s_pos ? (38'(SCALE_Q30) + 38'(s8_q[34:1])) : '0;
  assign fden  = s_pos ? s8_q[34:0] : 35'd1;

  logic        fd_valid;
  logic [37:0] fd_quo;
  logic [1:0]  fd_pay;

  ntcb_div #(
    .NW (38),
    .DW (35),
    .QW (38),
    .PW (2)
  ) u_div_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .num_i   (fnum),
    .den_i   (fden),
    .pay_i   ({err8_q, s_pos}),
    .valid_o (fd_valid),
    .quo_o   (fd_quo),
    .pay_o   (fd_pay)
  );

  // Kelvin to Celsius, saturation and error override.
  logic signed [39:0] t_c;
  logic signed [17:0] temp_d;

  assign t_c = $signed({2'b00, fd_quo}) - $signed(40'(KELVIN_OFFSET));

  always_comb begin
    if (fd_pay[1]) begin
      temp_d = TEMP_MIN;
    end else if (!fd_pay[0]) begin
      temp_d = TEMP_MAX;
    end else if (t_c > 40'(TEMP_MAX)) begin
      temp_d = TEMP_MAX;
    end else if (t_c < 40'(TEMP_MIN)) begin
      temp_d = TEMP_MIN;
    end else begin
      temp_d = t_c[17:0];
    end
  end

  // Output register.
  logic signed [17:0] temp_q;
  logic               rerr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q <= temp_d;
      rerr_q <= fd_pay[1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign temp_centi_c_o = temp_q;
  assign read_error_o   = rerr_q;

  // The two parallel dividers must stay in step.
  `NTCB_ASSERT_ALWAYS(a_div_in_step, bd_valid == td_valid, "reciprocal dividers out of step")
  // A read error always carries the error temperature.
  `NTCB_ASSERT_IMP(a_err_temp, out_valid_q && rerr_q, temp_q == TEMP_MIN, "error without -99900")
  // Every result lies in the saturated output range.
  `NTCB_ASSERT_IMP(a_temp_range, out_valid_q, (temp_q >= TEMP_MIN) && (temp_q <= TEMP_MAX), "temperature outside range")

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// NTC Beta temperature core testbench
// Drives directed and random samples through the core under several register
// settings and idling patterns, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ntcb_pkg::*;

  // Expected temperature result for one accepted sample.
  typedef struct {
    logic signed [17:0] temp;
    logic               err;
  } temp_result_t;

  // Scoreboard: holds the register copy and the queue of expected results.
  class temp_scoreboard;
    logic [12:0]        vcc;
    logic [19:0]        rs;
    logic [19:0]        r0;
    logic [13:0]        beta;
    logic signed [14:0] t0;
    temp_result_t       pending[$];
    int                 errors;

    function void reset_regs();
      vcc = SUPPLY_RST; rs = SERIES_RST; r0 = NOMINAL_RST;
      beta = BETA_RST; t0 = T0_RST;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] data);
      case (idx)
        REG_SUPPLY:  vcc = data[12:0];
        REG_SERIES:  rs = data;
        REG_NOMINAL: r0 = data;
        REG_BETA:    beta = data[13:0];
        REG_T0:      t0 = data[14:0];
        default: ;
      endcase
    endfunction

    // Base-2 logarithm of a Q16.16 ratio, in Q.24.
    function longint log2_ratio(bit [31:0] x);
      int     p;
      bit [63:0] m;
      longint frac;
      p = 31;
      frac = 0;
      while (p > 0 && x[p] == 1'b0) p--;
      if (p == 31) m = 64'(x >> 1);
      else m = 64'(x) << (30 - p);
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return longint'(p - 16) * 16777216 + frac;
    endfunction

    // Predicts the temperature for one sample and queues it.
    function void note_sample(logic [12:0] sample, logic is_mv);
      temp_result_t r;
      bit [63:0] v, num, den, ratio, mag;
      longint l, ln, s, tk, t, scale;
      longint unsigned b, r0e;
      scale = longint'(100) << 30;
      v = is_mv ? 64'(sample) : (64'(sample) * 3300) / 64'(4095);
      if (v == 0 || v >= 64'(vcc)) begin
        r.temp = TEMP_MIN;
        r.err = 1'b1;
      end else begin
        r0e = (r0 == 0) ? 1 : r0;
        b = (beta == 0) ? 1 : beta;
        num = (64'(rs) * (64'(vcc) - v)) << 16;
        den = v * 64'(r0e);
        ratio = num / den;
        if (ratio == 0) ratio = 1;
        if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
        l = log2_ratio(ratio[31:0]);
        mag = (l < 0) ? 64'(-l) : 64'(l);
        ln = longint'((mag * 64'(LN2_Q30)) >> 24);
        if (l < 0) ln = -ln;
        s = ln / longint'(b);
        s = s + scale / (longint'(t0) + 27315);
        if (s <= 0) t = TEMP_MAX;
        else begin
          tk = (scale + s / 2) / s;
          t = tk - 27315;
          if (t > TEMP_MAX) t = TEMP_MAX;
          if (t < TEMP_MIN) t = TEMP_MIN;
        end
        r.temp = 18'(t);
        r.err = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [17:0] temp, logic err);
      temp_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result temp_centi_c=%0d read_error=%0b", temp, err);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (temp !== e.temp) begin
        $error("temp_centi_c: expected %0d, actual %0d", e.temp, temp);
        errors++;
      end
      if (err !== e.err) begin
        $error("read_error: expected %0b, actual %0b", e.err, err);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [12:0]        sample_value_i = '0;
  logic               is_millivolts_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [17:0] temp_centi_c_o;
  logic               read_error_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [19:0]        cfg_wdata_i = '0;

  temp_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off = 1'b0;
  localparam int LATENCY_CYCLES = 400;

  ntc_thermistor_beta_temperature_core u_top (.*);

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(temp_centi_c_o, read_error_o);
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Offers one sample and waits for its transfer; may idle first.
  task automatic send_sample(logic [12:0] sample, logic is_mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= sample;
    is_millivolts_i <= is_mv;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(sample, is_mv);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  // Presents one register write and waits for the edge that takes it; the caller drops the enable.
  task automatic write_reg(logic [2:0] idx, logic [19:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic write_all(logic [19:0] vcc, logic [19:0] rs, logic [19:0] r0,
                           logic [19:0] beta, logic [19:0] t0);
    write_reg(REG_SUPPLY, vcc);
    write_reg(REG_SERIES, rs);
    write_reg(REG_NOMINAL, r0);
    write_reg(REG_BETA, beta);
    write_reg(REG_T0, t0);
    cfg_we_i <= 1'b0;
  endtask

  // Random sample, mostly inside the supply so the Beta path is exercised.
  task automatic send_random();
    logic [12:0] smp;
    logic        mv;
    mv = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       smp = 13'($urandom);
      1:       smp = 13'($urandom_range(3));
      default: smp = mv ? 13'($urandom_range((sb.vcc > 0) ? sb.vcc : 1))
                        : 13'($urandom_range(4095));
    endcase
    send_sample(smp, mv);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_random();
    drain();
  endtask

  // Stimulus.
  initial begin
    sb.reset_regs();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: field extremes, error limits and register corner cases.
    send_sample(13'd0, 1'b0);
    send_sample(13'd0, 1'b1);
    send_sample(13'd4095, 1'b0);
    send_sample(13'd8191, 1'b0);
    send_sample(13'd8191, 1'b1);
    send_sample(13'd1, 1'b1);
    send_sample(13'd3299, 1'b1);
    send_sample(13'd3300, 1'b1);
    send_sample(13'd1650, 1'b1);
    send_sample(13'd2048, 1'b0);
    send_sample(13'd1, 1'b0);
    send_sample(13'd4094, 1'b0);
    send_sample(13'h1555, 1'b1);
    send_sample(13'h0AAA, 1'b1);
    drain();
    // Zero resistors and Beta, and a zero supply.
    write_all(20'd3300, 20'd0, 20'd0, 20'd0, 20'd2500);
    send_sample(13'd1000, 1'b1);
    send_sample(13'd3000, 1'b1);
    drain();
    write_all(20'd0, 20'd1000000, 20'd1, 20'd1, 20'h7FFF & 20'(-5000));
    send_sample(13'd1, 1'b1);
    drain();
    write_all(20'd5000, 20'hFFFFF, 20'd1, 20'd1, 20'd15000);
    send_sample(13'd1, 1'b1);
    send_sample(13'd4999, 1'b1);
    drain();
    write_all(20'd5000, 20'd1, 20'hFFFFF, 20'h3FFF, 20'h4000);
    send_sample(13'd4999, 1'b1);
    send_sample(13'd1, 1'b1);
    drain();

    // Random phases with different settings and idling.
    write_all(SUPPLY_RST, SERIES_RST, NOMINAL_RST, BETA_RST, 20'(T0_RST));
    random_phase(200, 0, 0);
    random_phase(150, 80, 0);
    write_all(20'd5000, 20'd100000, 20'd47000, 20'd4250, 20'h7FFF & 20'(-5000));
    random_phase(150, 0, 80);
    random_phase(150, 22, 22);
    write_all(20'd1, 20'd1, 20'd1000000, 20'd1, 20'd15000);
    random_phase(50, 0, 0);
    for (int k = 0; k < 3; k++) begin
      write_all(20'($urandom_range(5000, 1)), 20'($urandom_range(1000000, 1)),
                20'($urandom_range(1000000, 1)), 20'($urandom_range(10000, 1)),
                20'h7FFF & 20'($urandom_range(20000) - 5000));
      random_phase(100, (k == 1) ? 80 : 0, (k == 2) ? 80 : 22);
    end

    // Long receiver hold-off while samples keep coming, then a full pause.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (150) send_random();
      end
    join
    drain();

    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ntcb_pkg.sv
design/ntcb_div.sv
design/ntcb_log2.sv
design/ntc_thermistor_beta_temperature_core.sv
tb/sv/tb_top.sv
